>>> hw/rtl/hnm_pkg.sv
`timescale 1ns / 1ps

package hnm_pkg;

  localparam int HEIGHT_W  = 16;
  localparam int DIFF_W    = HEIGHT_W + 1;
  localparam int MAG_W     = HEIGHT_W;
  localparam int SQR_W     = 2 * MAG_W;
  localparam int OUT_W     = 16;
  localparam int POS_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF = 256;
  localparam int DIM_RESET     = 257;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Root search: wide compare width and number of result bits.
  localparam int SQ_W   = 67;
  localparam int ITER_N = OUT_W - 1;
  localparam int ITER_W = 4;
  localparam int LANES  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);

  // One pixel worth of differences, handed from front to back.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
  } diff_t;

endpackage

>>> hw/rtl/height_to_normal_map.sv
`timescale 1ns / 1ps

// Height map to normal map. Height samples stream in raster order over a
// padded grid of grid_rows x grid_columns (register 0 = grid_columns,
// register 1 = grid_rows, both clamped to 2..MAX_WIDTH+1; a write restarts
// the frame). Each sample at row r >= 1, column c >= 1 yields the normal of
// pixel (r-1, c-1) from forward differences, normalized, scaled and biased
// to unsigned Q0.16 with exact round-half-up. The front end takes one sample
// per clock, while the queue has room, into a line buffer and forwards
// differences through a 4-entry queue; the back end works on one normal at
// a time through IDLE, SQUARE and SUM (setup), SEARCH (one root bit per
// cycle for 15 bits) and FINISH (output), so the sustained rate is set by
// the bit-serial root search. Samples that produce no normal (first row and
// first column) pass at one per clock while the queue has room. The normal
// output is a register, so the back end keeps working while a result waits.

module height_to_normal_map #(
  parameter int MAX_WIDTH = hnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hnm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                height_valid,
  output logic                                height_stall,
  input  logic signed [hnm_pkg::HEIGHT_W-1:0] height,
  output logic                                normal_valid,
  input  logic                                normal_stall,
  output logic [hnm_pkg::OUT_W-1:0]           normal_x,
  output logic [hnm_pkg::OUT_W-1:0]           normal_y,
  output logic [hnm_pkg::OUT_W-1:0]           normal_z,
  output logic [hnm_pkg::POS_W-1:0]           pixel_row,
  output logic [hnm_pkg::POS_W-1:0]           pixel_column,
  output logic                                last_of_frame
);

  logic                       push;
  logic                       pop;
  logic                       q_empty;
  logic [hnm_pkg::QCNT_W-1:0] q_count;
  hnm_pkg::diff_t             push_data;
  hnm_pkg::diff_t             q_head;

  // Register writes are taken every cycle.
  assign cfg_ready = 1'b1;

  hnm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .height_valid (height_valid),
    .height       (height),
    .height_stall (height_stall),
    .q_count      (q_count),
    .push         (push),
    .push_data    (push_data)
  );

  hnm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  hnm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .normal_valid  (normal_valid),
    .normal_stall  (normal_stall),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .pixel_row     (pixel_row),
    .pixel_column  (pixel_column),
    .last_of_frame (last_of_frame)
  );

endmodule

>>> hw/rtl/hnm_fifo.sv
`timescale 1ns / 1ps

module hnm_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  hnm_pkg::diff_t             push_data,
  input  logic                       pop,
  output hnm_pkg::diff_t             head,
  output logic                       empty,
  output logic [hnm_pkg::QCNT_W-1:0] count
);

  hnm_pkg::diff_t                entries [hnm_pkg::QDEPTH];
  logic [hnm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [hnm_pkg::QPTR_W-1:0]    rd_ptr;

  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + hnm_pkg::QCNT_W'(push) - hnm_pkg::QCNT_W'(pop);
    end
  end

endmodule

>>> hw/rtl/hnm_front.sv
`timescale 1ns / 1ps

module hnm_front #(
  parameter int MAX_WIDTH = hnm_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [hnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hnm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          height_valid,
  input  logic signed [hnm_pkg::HEIGHT_W-1:0] height,
  output logic                          height_stall,
  input  logic [hnm_pkg::QCNT_W-1:0]    q_count,
  output logic                          push,
  output hnm_pkg::diff_t                push_data
);

  localparam int LIMIT = MAX_WIDTH + 1;
  localparam int AW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int RESET_DIM = (hnm_pkg::DIM_RESET > LIMIT) ? LIMIT : hnm_pkg::DIM_RESET;

  logic signed [hnm_pkg::HEIGHT_W-1:0] line_mem [LIMIT];

  logic [hnm_pkg::CFG_W-1:0] grid_columns;
  logic [hnm_pkg::CFG_W-1:0] grid_rows;
  logic [hnm_pkg::CFG_W-1:0] column_count;
  logic [hnm_pkg::CFG_W-1:0] row_count;
  logic signed [hnm_pkg::HEIGHT_W-1:0] prior_sample;
  logic signed [hnm_pkg::HEIGHT_W-1:0] last_val;
  logic signed [hnm_pkg::HEIGHT_W-1:0] here_reg;
  logic signed [hnm_pkg::HEIGHT_W-1:0] mem_q;

  // stage 1: memory read in flight
  logic                               s1_valid;
  logic                               s1_emit;
  logic                               s1_use_last;
  logic signed [hnm_pkg::HEIGHT_W-1:0] s1_below;
  logic signed [hnm_pkg::HEIGHT_W-1:0] s1_last_val;
  logic [hnm_pkg::POS_W-1:0]          s1_row;
  logic [hnm_pkg::POS_W-1:0]          s1_col;
  logic                               s1_lof;

  logic [hnm_pkg::CFG_W-1:0] cfg_clamped;
  logic [hnm_pkg::CFG_W-1:0] c;
  logic [hnm_pkg::CFG_W-1:0] r;
  logic                      last_col;
  logic                      last_row;
  logic                      accept;
  logic signed [hnm_pkg::HEIGHT_W-1:0] right;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data < hnm_pkg::CFG_W'(2)) begin
      cfg_clamped = hnm_pkg::CFG_W'(2);
    end else if (32'(cfg_data) > 32'(LIMIT)) begin
      cfg_clamped = hnm_pkg::CFG_W'(LIMIT);
    end
  end

  assign c = (column_count >= grid_columns) ? grid_columns - 1'b1 : column_count;
  assign r = (row_count >= grid_rows) ? grid_rows - 1'b1 : row_count;
  assign last_col = (c == grid_columns - 1'b1);
  assign last_row = (r == grid_rows - 1'b1);

  assign height_stall = (hnm_pkg::QCNT_W'(q_count + hnm_pkg::QCNT_W'(s1_valid))
                         >= hnm_pkg::QCNT_W'(hnm_pkg::QDEPTH));
  assign accept = height_valid && !height_stall;

  // Line buffer: read column c, write column c-1 with the previous sample.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= line_mem[AW'(c)];
      if (c != '0) begin
        line_mem[AW'(c - 1'b1)] <= prior_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit     <= (c != '0) && (r != '0);
      s1_use_last <= last_col;
      s1_below    <= prior_sample;
      s1_last_val <= last_val;
      s1_row      <= hnm_pkg::POS_W'(r - 1'b1);
      s1_col      <= hnm_pkg::POS_W'(c - 1'b1);
      s1_lof      <= last_col && last_row;
      if (last_col) last_val <= height;
    end
    if (s1_valid) begin
      here_reg <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= hnm_pkg::CFG_W'(RESET_DIM);
      grid_rows    <= hnm_pkg::CFG_W'(RESET_DIM);
      column_count <= '0;
      row_count    <= '0;
      prior_sample <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_valid && (cfg_index == hnm_pkg::REG_GRID_COLUMNS ||
                        cfg_index == hnm_pkg::REG_GRID_ROWS)) begin
        if (cfg_index == hnm_pkg::REG_GRID_COLUMNS) grid_columns <= cfg_clamped;
        else grid_rows <= cfg_clamped;
        column_count <= '0;
        row_count    <= '0;
      end else if (accept) begin
        prior_sample <= height;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : r + 1'b1;
        end else begin
          column_count <= c + 1'b1;
          row_count    <= r;
        end
      end
    end
  end

  // stage 2: form the differences
  assign right = s1_use_last ? s1_last_val : mem_q;
  assign push  = s1_valid && s1_emit;

  always_comb begin
    push_data.dx   = hnm_pkg::DIFF_W'(here_reg) - hnm_pkg::DIFF_W'(s1_below);
    push_data.dy   = hnm_pkg::DIFF_W'(here_reg) - hnm_pkg::DIFF_W'(right);
    push_data.row  = s1_row;
    push_data.col  = s1_col;
    push_data.last = s1_lof;
  end

endmodule

>>> hw/rtl/hnm_back.sv
`timescale 1ns / 1ps

module hnm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  hnm_pkg::diff_t              q_head,
  output logic                        pop,
  output logic                        normal_valid,
  input  logic                        normal_stall,
  output logic [hnm_pkg::OUT_W-1:0]   normal_x,
  output logic [hnm_pkg::OUT_W-1:0]   normal_y,
  output logic [hnm_pkg::OUT_W-1:0]   normal_z,
  output logic [hnm_pkg::POS_W-1:0]   pixel_row,
  output logic [hnm_pkg::POS_W-1:0]   pixel_column,
  output logic                        last_of_frame
);

  localparam int SW = hnm_pkg::SQ_W;
  localparam int MW = hnm_pkg::ITER_N;
  localparam logic [hnm_pkg::OUT_W:0] HALF = (hnm_pkg::OUT_W + 1)'(1) << (hnm_pkg::OUT_W - 1);

  typedef enum logic [2:0] {IDLE, SQUARE, SUM, SEARCH, FINISH} state_t;

  state_t                       state;
  hnm_pkg::diff_t               item;
  logic [hnm_pkg::SQR_W-1:0]    sqx;
  logic [hnm_pkg::SQR_W-1:0]    sqy;
  logic [SW-1:0]                s;
  logic [SW-1:0]                bound [hnm_pkg::LANES];
  logic                         neg   [hnm_pkg::LANES];
  logic [SW-1:0]                acc_a [hnm_pkg::LANES];
  logic [SW-1:0]                acc_m [hnm_pkg::LANES];
  logic [MW-1:0]                root  [hnm_pkg::LANES];
  logic [hnm_pkg::ITER_W-1:0]   bit_idx;

  logic [SW-1:0]                cand_a [hnm_pkg::LANES];
  logic [SW-1:0]                cand_m [hnm_pkg::LANES];
  logic                         pass   [hnm_pkg::LANES];
  logic [hnm_pkg::OUT_W-1:0]    comp   [hnm_pkg::LANES];

  logic [hnm_pkg::MAG_W-1:0]    mag_x;
  logic [hnm_pkg::MAG_W-1:0]    mag_y;
  logic                         out_free;

  assign mag_x = hnm_pkg::MAG_W'(item.dx < 0 ? -item.dx : item.dx);
  assign mag_y = hnm_pkg::MAG_W'(item.dy < 0 ? -item.dy : item.dy);
  assign pop      = (state == IDLE) && !q_empty;
  assign out_free = !normal_valid || !normal_stall;

  // One result bit per lane per cycle: try m | 2^j with
  // (2m+1)^2*s = 4*m^2*s + 4*m*s + s against the scaled bound.
  always_comb begin
    logic [SW-1:0] val;
    logic [SW-1:0] cnt;
    logic          c0;
    for (int i = 0; i < hnm_pkg::LANES; i++) begin
      cand_a[i] = acc_a[i] + (acc_m[i] << (bit_idx + 1'b1)) + (s << {bit_idx, 1'b0});
      cand_m[i] = acc_m[i] + (s << bit_idx);
      val       = (cand_a[i] << 2) + (cand_m[i] << 2) + s;
      pass[i]   = neg[i] ? (val < bound[i]) : (val <= bound[i]);
      c0        = neg[i] ? (s < bound[i]) : (s <= bound[i]);
      cnt       = c0 ? SW'(root[i]) + SW'(1) : '0;
      if (neg[i]) begin
        comp[i] = hnm_pkg::OUT_W'(HALF - (hnm_pkg::OUT_W + 1)'(cnt));
      end else if ((HALF + (hnm_pkg::OUT_W + 1)'(cnt)) >
                   (hnm_pkg::OUT_W + 1)'({hnm_pkg::OUT_W{1'b1}})) begin
        comp[i] = {hnm_pkg::OUT_W{1'b1}};
      end else begin
        comp[i] = hnm_pkg::OUT_W'(HALF + (hnm_pkg::OUT_W + 1)'(cnt));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      normal_valid <= 1'b0;
    end else begin
      // In FINISH with a free output the new result replaces the old one.
      if (normal_valid && !normal_stall && state != FINISH) normal_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (!q_empty) begin
            item  <= q_head;
            state <= SQUARE;
          end
        end
        SQUARE: begin
          sqx   <= mag_x * mag_x;
          sqy   <= mag_y * mag_y;
          state <= SUM;
        end
        SUM: begin
          s        <= SW'(sqx) + SW'(sqy) + SW'(1);
          bound[0] <= SW'(sqx) << hnm_pkg::SQR_W;
          bound[1] <= SW'(sqy) << hnm_pkg::SQR_W;
          bound[2] <= SW'(1) << hnm_pkg::SQR_W;
          neg[0]   <= item.dx < 0;
          neg[1]   <= item.dy < 0;
          neg[2]   <= 1'b0;
          for (int i = 0; i < hnm_pkg::LANES; i++) begin
            acc_a[i] <= '0;
            acc_m[i] <= '0;
            root[i]  <= '0;
          end
          bit_idx <= hnm_pkg::ITER_W'(MW - 1);
          state   <= SEARCH;
        end
        SEARCH: begin
          for (int i = 0; i < hnm_pkg::LANES; i++) begin
            if (pass[i]) begin
              acc_a[i] <= cand_a[i];
              acc_m[i] <= cand_m[i];
              root[i]  <= root[i] | (MW'(1) << bit_idx);
            end
          end
          if (bit_idx == '0) state <= FINISH;
          else bit_idx <= bit_idx - 1'b1;
        end
        FINISH: begin
          if (out_free) begin
            normal_x      <= comp[0];
            normal_y      <= comp[1];
            normal_z      <= comp[2];
            pixel_row     <= item.row;
            pixel_column  <= item.col;
            last_of_frame <= item.last;
            normal_valid  <= 1'b1;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/height_to_normal_map_checker.sv
`timescale 1ns / 1ps

// Watches the config, height and normal channels, predicts each normal from
// the accepted heights and compares it with what the block returns.
module height_to_normal_map_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hnm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                height_valid,
  input  logic                                height_stall,
  input  logic signed [hnm_pkg::HEIGHT_W-1:0] height,
  input  logic                                normal_valid,
  input  logic                                normal_stall,
  input  logic [hnm_pkg::OUT_W-1:0]           normal_x,
  input  logic [hnm_pkg::OUT_W-1:0]           normal_y,
  input  logic [hnm_pkg::OUT_W-1:0]           normal_z,
  input  logic [hnm_pkg::POS_W-1:0]           pixel_row,
  input  logic [hnm_pkg::POS_W-1:0]           pixel_column,
  input  logic                                last_of_frame,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int MAX_W = hnm_pkg::MAX_WIDTH_DEF;
  localparam int OW    = hnm_pkg::OUT_W;
  localparam int PW    = hnm_pkg::POS_W;

  typedef struct packed {
    logic [OW-1:0] x;
    logic [OW-1:0] y;
    logic [OW-1:0] z;
    logic [PW-1:0] row;
    logic [PW-1:0] col;
    logic          last;
  } normal_t;

  normal_t normals_due[$];
  int      line_buf[0:MAX_W];
  int      prev_h;
  int      col_cnt;
  int      row_cnt;
  int      num_cols;
  int      num_rows;

  assign pending = normals_due.size();

  function automatic int clamp_dim(logic [hnm_pkg::CFG_W-1:0] v);
    int d;
    d = int'(v);
    if (d < 2) d = 2;
    if (d > MAX_W + 1) d = MAX_W + 1;
    return d;
  endfunction

  // Exact round-half-up of 2^16 * (0.5*v/sqrt(s) + 0.5), by binary search on
  // squared comparisons so no square root is ever taken.
  function automatic logic [OW-1:0] unit_component(longint v, longint unsigned s);
    longint unsigned half, mag, b, lo, hi, mid, res;
    logic [127:0]    lhs, rhs;
    half = 64'd1 << (OW - 1);
    mag  = (v < 0) ? longint'(-v) : longint'(v);
    b    = 2 * half * mag;
    rhs  = 128'(b) * 128'(b);
    lo   = 0;
    hi   = half;
    if (v >= 0) begin
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(s);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      res = half + lo;
    end else begin
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        lhs = 128'(2 * mid + 1) * 128'(2 * mid + 1) * 128'(s);
        if (lhs >= rhs) hi = mid;
        else lo = mid + 1;
      end
      res = half - lo;
    end
    if (res > (64'd1 << OW) - 1) res = (64'd1 << OW) - 1;
    return res[OW-1:0];
  endfunction

  task automatic predict_normal(int h);
    int              c, r;
    bit              last_col, last_row;
    longint          dx, dy;
    longint unsigned s;
    normal_t         n;
    c = col_cnt;
    r = row_cnt;
    if (c >= num_cols) c = num_cols - 1;
    if (r >= num_rows) r = num_rows - 1;
    last_col = (c == num_cols - 1);
    last_row = (r == num_rows - 1);
    if (c >= 1) begin
      if (r >= 1) begin
        dx     = longint'(line_buf[c-1]) - longint'(prev_h);
        dy     = longint'(line_buf[c-1]) - longint'(line_buf[c]);
        s      = longint'(dx * dx + dy * dy + 1);
        n.x    = unit_component(dx, s);
        n.y    = unit_component(dy, s);
        n.z    = unit_component(1, s);
        n.row  = PW'(r - 1);
        n.col  = PW'(c - 1);
        n.last = last_col && last_row;
        normals_due.push_back(n);
      end
      line_buf[c-1] = prev_h;
      if (last_col) line_buf[c] = h;
    end
    prev_h = h;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    normal_t n;
    if (rst) begin
      normals_due.delete();
      foreach (line_buf[i]) line_buf[i] = 0;
      prev_h     = 0;
      col_cnt    = 0;
      row_cnt    = 0;
      num_cols   = MAX_W + 1;
      num_rows   = MAX_W + 1;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == hnm_pkg::REG_GRID_COLUMNS || cfg_index == hnm_pkg::REG_GRID_ROWS) begin
          if (cfg_index == hnm_pkg::REG_GRID_COLUMNS) num_cols = clamp_dim(cfg_data);
          else num_rows = clamp_dim(cfg_data);
          col_cnt = 0;
          row_cnt = 0;
        end
      end
      if (height_valid && !height_stall) predict_normal(int'(height));
      if (normal_valid && !normal_stall) begin
        if (normals_due.size() == 0) begin
          $error("normal with none expected: row %0d column %0d", pixel_row, pixel_column);
          fail_count++;
        end else begin
          n = normals_due.pop_front();
          check_field("normal_x", n.x, normal_x);
          check_field("normal_y", n.y, normal_y);
          check_field("normal_z", n.z, normal_z);
          check_field("pixel_row", n.row, pixel_row);
          check_field("pixel_column", n.col, pixel_column);
          check_field("last_of_frame", n.last, last_of_frame);
        end
      end
    end
  end

endmodule

>>> tb/sv/height_to_normal_map_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict. The checker beside the DUT does all prediction.
module height_to_normal_map_tb;

  localparam int CYCLE_LIMIT = 2000000;
  // Back end works on one normal at a time with a 4-deep queue in front;
  // this comfortably covers anything still in flight.
  localparam int SETTLE_CYCLES = 200;
  localparam int IW = hnm_pkg::CFG_IDX_W;
  localparam int CW = hnm_pkg::CFG_W;
  localparam int HW = hnm_pkg::HEIGHT_W;

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [IW-1:0]                       cfg_index;
  logic [CW-1:0]                       cfg_data;
  logic                                height_valid;
  logic                                height_stall;
  logic signed [HW-1:0]                height;
  logic                                normal_valid;
  logic                                normal_stall;
  logic [hnm_pkg::OUT_W-1:0]           normal_x;
  logic [hnm_pkg::OUT_W-1:0]           normal_y;
  logic [hnm_pkg::OUT_W-1:0]           normal_z;
  logic [hnm_pkg::POS_W-1:0]           pixel_row;
  logic [hnm_pkg::POS_W-1:0]           pixel_column;
  logic                                last_of_frame;

  int fail_count;
  int pending;
  int cycle_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int heights_sent;

  height_to_normal_map u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .height_valid(height_valid), .height_stall(height_stall), .height(height),
    .normal_valid(normal_valid), .normal_stall(normal_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .pixel_row(pixel_row), .pixel_column(pixel_column),
    .last_of_frame(last_of_frame)
  );

  height_to_normal_map_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .height_valid(height_valid), .height_stall(height_stall), .height(height),
    .normal_valid(normal_valid), .normal_stall(normal_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .pixel_row(pixel_row), .pixel_column(pixel_column),
    .last_of_frame(last_of_frame),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle independent of normal_valid.
  always @(negedge clk) begin
    normal_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One height transaction, with random idle cycles in front of it.
  task automatic send_height(logic signed [HW-1:0] h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      height_valid <= 1'b0;
      @(negedge clk);
    end
    height_valid <= 1'b1;
    height       <= h;
    do @(posedge clk); while (height_stall);
    heights_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    height_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(int cols, int rows);
    write_reg(hnm_pkg::REG_GRID_COLUMNS, CW'(cols));
    write_reg(hnm_pkg::REG_GRID_ROWS, CW'(rows));
  endtask

  // Mix: full-range noise, rail values, and gentle slopes that give
  // normals away from the saturation corners.
  function automatic logic signed [HW-1:0] rand_height(ref int base);
    int pick;
    pick = $urandom_range(7);
    if (pick < 2) return HW'($urandom);
    if (pick == 2) begin
      case ($urandom_range(2))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        default: return 16'sh0000;
      endcase
    end
    base = base + $urandom_range(8) - 4;
    if (base > 32767) base = 32767;
    if (base < -32768) base = -32768;
    return HW'(base);
  endfunction

  task automatic run_phase(int n_items, int idle_mode, bit pause_mid);
    int base;
    base = int'($urandom_range(2000)) - 1000;
    case (idle_mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
    for (int i = 0; i < n_items; i++) begin
      // Let the whole pipeline empty once with the sender quiet.
      if (pause_mid && i == n_items / 2) begin
        @(negedge clk);
        height_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_height(rand_height(base));
    end
    drain();
  endtask

  // Directed frame: rails next to each other, then a flat patch.
  logic signed [HW-1:0] directed_hts [12] = '{
    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000,
    16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0005,
    16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005
  };

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    height_valid   = 1'b0;
    height         = '0;
    normal_stall   = 1'b0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    heights_sent   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Indexes past the register list must be ignored.
    write_reg(IW'(2), CW'(3));
    write_reg(IW'(3), CW'(5));

    // Directed: small 4x3 grid, rail-to-rail steps, then an all-flat frame.
    set_grid(4, 3);
    foreach (directed_hts[i]) send_height(directed_hts[i]);
    for (int i = 0; i < 12; i++) send_height(16'sh0064);
    drain();

    // Widest grid, two rows: reaches column 255 and end of frame;
    // includes the full pause.
    set_grid(257, 2);
    run_phase(514, 0, 1'b1);

    // Out-of-range values clamp: 0 and 1 become 2, 300 becomes 257.
    set_grid(1, 0);
    run_phase(20, 2, 1'b0);
    set_grid(0, 300);
    run_phase(20, 3, 1'b0);
    set_grid(6, 5);
    run_phase(30, 1, 1'b0);
    set_grid(9, 4);
    run_phase(20, 3, 1'b0);

    $display("Covered %0d height samples over grids from 2x2 up to 257 wide,",
             heights_sent);
    $display("with clamped register values, rails, flat areas and random back-pressure.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
